### rtl/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window median filter.
// Used by the controller, the datapath, the top level and the testbench; no dependencies.
package swm_pkg;

  // Window storage depth and derived widths
  localparam int WINDOW_MAX = 64;
  localparam int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW         = $clog2(WINDOW_MAX + 1);

  // Field widths
  localparam int SAMPLE_W    = 32;
  localparam int MED_W       = SAMPLE_W + 1;
  localparam int WS_W        = 7;
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MED_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_WINDOW_SIZE = '0;
  localparam logic [WS_W-1:0]   WS_RESET        = WS_W'(3);

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIND0,
    ST_FIND,
    ST_REM,
    ST_INS_ST,
    ST_INS,
    ST_INS_LAST,
    ST_COMMIT,
    ST_CHKOUT,
    ST_MED_B,
    ST_MED_C,
    ST_OUT
  } swm_state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_RING,
    OP_FIND_FIRST,
    OP_FIND_STEP,
    OP_REM_STEP,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_LAST,
    OP_COMMIT,
    OP_MED_HI,
    OP_MED_LO,
    OP_MED_ODD,
    OP_MED_EVEN,
    OP_OUT_LOAD
  } swm_op_t;

  typedef struct packed {
    swm_op_t op;
  } swm_cmd_t;

  typedef struct packed {
    logic k_zero;    // window size is zero
    logic full;      // fill count equals window size
    logic match;     // read entry equals the oldest sample
    logic at_last;   // scan index sits on the last entry
    logic ins_stop;  // read entry is not above the new sample
    logic idx_zero;  // scan index is zero
    logic m_zero;    // working count is zero
    logic k_odd;     // window size is odd
    logic out_free;  // output register can take a result
  } swm_sts_t;

endpackage

### rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// Sliding window median filter, top level. One sample at a time is merged into a
// sorted window RAM; each pass scans that RAM one entry per cycle through its
// read port and write port. A full window removes its oldest sample before the insert;
// once the window is full the median is read and the block waits for a free output
// register before it takes the next sample. Zero window drops one per cycle.
// Synchronous active-low reset clears counters and handshake state; no clearing
// pass, the block takes requests from the first cycle after reset.
module sliding_window_median (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [swm_pkg::IN_TDATA_W-1:0]       in_tdata,    // [31:0] sample
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]      out_tdata,   // [32:0] median_doubled
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [swm_pkg::CFG_AW-1:0]           cfg_paddr,
  input  logic [swm_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic [swm_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                 cfg_pready
);
  import swm_pkg::*;

  logic [WS_W-1:0]         ws_r, ws_nxt;
  logic                    cfg_hit;
  logic                    cfg_wr;
  swm_cmd_t                cmd;
  swm_sts_t                sts;
  logic signed [MED_W-1:0] median;

  // Register decode
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_WINDOW_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? CFG_DW'(ws_r) : '0;

  always_comb begin
    ws_nxt = ws_r;
    if (cfg_wr) ws_nxt = cfg_pwdata[WS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else begin
      ws_r <= ws_nxt;
    end
  end

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .window_size (ws_r),
    .cfg_clear   (cfg_wr),
    .in_sample   (in_tdata[SAMPLE_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_median  (median)
  );

  assign out_tdata = {{(OUT_TDATA_W-MED_W){1'b0}}, median};

  // An accepted sample in a live window keeps the sequencer busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !sts.k_zero) |=> !in_tready)
    else $error("sample accepted but sequencer did not start");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT_LOAD) |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

  // A new result appears only after the sequencer loaded it
  a_rose_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == OP_OUT_LOAD))
    else $error("result valid without a load");

endmodule

### rtl/swm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/swm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the median filter: walks each sample through remove, insert
// and median read. Depends on swm_pkg.
module swm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t cmd
);
  import swm_pkg::*;

  swm_state_t state_r;
  swm_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.k_zero) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.full) state_nxt = ST_FIND0;
        else if (sts.m_zero) state_nxt = ST_COMMIT;
        else state_nxt = ST_INS;
      end
      ST_FIND0: state_nxt = ST_FIND;
      ST_FIND: begin
        if (sts.at_last) state_nxt = ST_INS_ST;
        else if (sts.match) state_nxt = ST_REM;
      end
      ST_REM: begin
        if (sts.at_last) state_nxt = ST_INS_ST;
      end
      ST_INS_ST: begin
        if (sts.m_zero) state_nxt = ST_COMMIT;
        else state_nxt = ST_INS;
      end
      ST_INS: begin
        if (sts.ins_stop) state_nxt = ST_COMMIT;
        else if (sts.idx_zero) state_nxt = ST_INS_LAST;
      end
      ST_INS_LAST: state_nxt = ST_COMMIT;
      ST_COMMIT:   state_nxt = ST_CHKOUT;
      ST_CHKOUT: begin
        if (sts.full) state_nxt = ST_MED_B;
        else state_nxt = ST_IDLE;
      end
      ST_MED_B: begin
        if (sts.k_odd) state_nxt = ST_OUT;
        else state_nxt = ST_MED_C;
      end
      ST_MED_C: state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath operation
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !sts.k_zero) cmd.op = OP_LOAD;
      end
      ST_CHECK:    cmd.op = sts.full ? OP_RD_RING : OP_INS_START;
      ST_FIND0:    cmd.op = OP_FIND_FIRST;
      ST_FIND:     cmd.op = OP_FIND_STEP;
      ST_REM:      cmd.op = OP_REM_STEP;
      ST_INS_ST:   cmd.op = OP_INS_START;
      ST_INS:      cmd.op = OP_INS_STEP;
      ST_INS_LAST: cmd.op = OP_INS_LAST;
      ST_COMMIT:   cmd.op = OP_COMMIT;
      ST_CHKOUT:   cmd.op = sts.full ? OP_MED_HI : OP_NONE;
      ST_MED_B:    cmd.op = sts.k_odd ? OP_MED_ODD : OP_MED_LO;
      ST_MED_C:    cmd.op = OP_MED_EVEN;
      ST_OUT:      cmd.op = sts.out_free ? OP_OUT_LOAD : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/swm_dp.sv
`timescale 1ns / 1ps
// Datapath for the median filter: sorted window RAM, arrival ring RAM,
// counters, scan index and output register. Depends on swm_pkg and swm_ram.
module swm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swm_pkg::WS_W-1:0]            window_size,
  input  logic                                cfg_clear,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
  input  swm_pkg::swm_cmd_t                   cmd,
  output swm_pkg::swm_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [swm_pkg::MED_W-1:0]    out_median
);
  import swm_pkg::*;

  // Effective window size and median positions
  logic [CW-1:0] k;
  logic [AW-1:0] med_hi;

  // Control state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers
  logic [CW-1:0]              m_r, m_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [SAMPLE_W-1:0] old_r, old_nxt;
  logic signed [SAMPLE_W-1:0] med_a_r, med_a_nxt;
  logic signed [MED_W-1:0]    med_r, med_nxt;
  logic signed [MED_W-1:0]    out_med_r, out_med_nxt;

  // RAM ports
  logic                s_we, s_re, r_we, r_re;
  logic [AW-1:0]       s_waddr, s_raddr;
  logic [SAMPLE_W-1:0] s_wdata, s_rdata, r_rdata;
  logic signed [SAMPLE_W-1:0] s_rd;
  logic [CW-1:0]       wptr_inc;

  assign k = ({{(32-WS_W){1'b0}}, window_size} > WINDOW_MAX) ? CW'(WINDOW_MAX)
                                                              : CW'(window_size);
  assign med_hi   = AW'(k >> 1);
  assign s_rd     = s_rdata;
  assign wptr_inc = CW'(wptr_r) + CW'(1);

  swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_sorted (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (r_we),
    .waddr (wptr_r),
    .wdata (sample_r),
    .re    (r_re),
    .raddr (wptr_r),
    .rdata (r_rdata)
  );

  // Execute the requested operation
  always_comb begin
    cnt_nxt       = cnt_r;
    wptr_nxt      = wptr_r;
    m_nxt         = m_r;
    idx_nxt       = idx_r;
    sample_nxt    = sample_r;
    old_nxt       = old_r;
    med_a_nxt     = med_a_r;
    med_nxt       = med_r;
    out_med_nxt   = out_med_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    s_we          = 1'b0;
    s_waddr       = idx_r;
    s_wdata       = sample_r;
    s_re          = 1'b0;
    s_raddr       = idx_r;
    r_we          = 1'b0;
    r_re          = 1'b0;
    case (cmd.op)
      OP_LOAD: begin
        // take the sample, clamp count and pointer to the window
        sample_nxt = in_sample;
        cnt_nxt    = (cnt_r > k) ? k : cnt_r;
        m_nxt      = (cnt_r > k) ? k : cnt_r;
        wptr_nxt   = (CW'(wptr_r) >= k) ? '0 : wptr_r;
      end
      OP_RD_RING: r_re = 1'b1;
      OP_FIND_FIRST: begin
        // hold the oldest sample, start the scan at the bottom
        old_nxt = r_rdata;
        m_nxt   = m_r - CW'(1);
        s_re    = 1'b1;
        s_raddr = '0;
        idx_nxt = '0;
      end
      OP_FIND_STEP: begin
        s_re    = 1'b1;
        s_raddr = idx_r + AW'(1);
        idx_nxt = idx_r + AW'(1);
      end
      OP_REM_STEP: begin
        // close the gap: move each entry down one place
        s_we    = 1'b1;
        s_waddr = idx_r - AW'(1);
        s_wdata = s_rdata;
        s_re    = 1'b1;
        s_raddr = idx_r + AW'(1);
        idx_nxt = idx_r + AW'(1);
      end
      OP_INS_START: begin
        if (m_r == '0) begin
          s_we    = 1'b1;
          s_waddr = '0;
        end else begin
          s_re    = 1'b1;
          s_raddr = AW'(m_r - CW'(1));
          idx_nxt = AW'(m_r - CW'(1));
        end
      end
      OP_INS_STEP: begin
        // shift larger entries up until the slot for the sample is found
        s_we    = 1'b1;
        s_waddr = idx_r + AW'(1);
        if (s_rd > sample_r) begin
          s_wdata = s_rdata;
          s_re    = 1'b1;
          s_raddr = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end
      OP_INS_LAST: begin
        s_we    = 1'b1;
        s_waddr = '0;
      end
      OP_COMMIT: begin
        // record arrival, advance the ring
        r_we     = 1'b1;
        cnt_nxt  = m_r + CW'(1);
        wptr_nxt = (wptr_inc >= k) ? '0 : AW'(wptr_inc);
      end
      OP_MED_HI: begin
        s_re    = 1'b1;
        s_raddr = med_hi;
      end
      OP_MED_LO: begin
        med_a_nxt = s_rd;
        s_re      = 1'b1;
        s_raddr   = med_hi - AW'(1);
      end
      OP_MED_ODD:  med_nxt = {s_rd, 1'b0};
      OP_MED_EVEN: med_nxt = {med_a_r[SAMPLE_W-1], med_a_r} + {s_rd[SAMPLE_W-1], s_rd};
      OP_OUT_LOAD: begin
        out_med_nxt   = med_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
    // a configuration write restarts the window
    if (cfg_clear) begin
      cnt_nxt  = '0;
      wptr_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      wptr_r      <= wptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    idx_r     <= idx_nxt;
    sample_r  <= sample_nxt;
    old_r     <= old_nxt;
    med_a_r   <= med_a_nxt;
    med_r     <= med_nxt;
    out_med_r <= out_med_nxt;
  end

  // Status to the controller
  always_comb begin
    sts.k_zero   = (k == '0);
    sts.full     = (cnt_r == k);
    sts.match    = (s_rd == old_r);
    sts.at_last  = (CW'(idx_r) == m_r);
    sts.ins_stop = !(s_rd > sample_r);
    sts.idx_zero = (idx_r == '0);
    sts.m_zero   = (m_r == '0);
    sts.k_odd    = k[0];
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_med_r;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_median: stream samples in, check medians out.
// Depends on rtl/swm_pkg.sv and rtl/sliding_window_median.sv; a scoreboard class predicts.
module tb;

  localparam int          LIMIT_CYCLES = 4_000_000;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          HOLD_CYCLES  = 3000;
  localparam logic [0:0]  REG_UNUSED   = 1'b1;
  localparam logic [31:0] S_MIN        = 32'h8000_0000;
  localparam logic [31:0] S_MAX        = 32'h7FFF_FFFF;

  localparam logic [31:0] ODD_RUN[12] = '{
    S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
    32'h0, 32'hFFFF_FFFF, 32'h1, 32'h7, 32'h7, 32'hFFFF_FFF9
  };
  localparam logic [31:0] EVEN_RUN[6] = '{
    S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, 32'h5
  };
  localparam int FORCED_WS[5] = '{1, 5, 64, 127, 0};

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [swm_pkg::IN_TDATA_W-1:0]    in_tdata;    // [31:0] sample
  logic                              out_tvalid;
  logic                              out_tready;
  logic [swm_pkg::OUT_TDATA_W-1:0]   out_tdata;   // [32:0] median_doubled
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [swm_pkg::CFG_AW-1:0]        cfg_paddr;
  logic [swm_pkg::CFG_DW-1:0]        cfg_pwdata;
  logic [swm_pkg::CFG_DW-1:0]        cfg_prdata;
  logic                              cfg_pready;

  bit hold_results;

  // Running median predictor and store of expected medians
  class median_scoreboard;
    logic signed [31:0] sorted_win[swm_pkg::WINDOW_MAX];
    logic signed [31:0] arrivals[swm_pkg::WINDOW_MAX];
    int                 fill;
    int                 widx;
    logic [6:0]         wsize;
    logic signed [32:0] expected_medians[$];
    int                 errors;

    function new();
      fill   = 0;
      widx   = 0;
      wsize  = swm_pkg::WS_RESET;
      errors = 0;
    endfunction

    function int eff_size();
      return (wsize > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : int'(wsize);
    endfunction

    // Apply a register write; only the window size register exists
    function void set_window(logic [swm_pkg::CFG_AW-1:0] addr, logic [31:0] data);
      if (addr[swm_pkg::CFG_AW-1:2] != swm_pkg::REG_WINDOW_SIZE) return;
      wsize = data[6:0];
      fill  = 0;
      widx  = 0;
    endfunction

    // Merge an accepted sample and queue the median it produces, if any
    function void take_sample(logic signed [31:0] s);
      int k;
      int n;
      int w;
      int i;
      int j;
      logic signed [32:0] lo;
      logic signed [32:0] hi;
      k = eff_size();
      if (k == 0) return;
      n = fill;
      w = widx;
      if (w >= k) w = 0;
      if (n > k) n = k;
      // drop the oldest sample: first equal entry in sorted order
      if (n == k) begin
        i = 0;
        while (i < n && sorted_win[i] != arrivals[w]) i++;
        if (i < n) begin
          for (j = i; j + 1 < n; j++) sorted_win[j] = sorted_win[j + 1];
          n--;
        end
      end
      // insert the new sample, keep ascending order
      i = n;
      while (i > 0 && sorted_win[i - 1] > s) begin
        sorted_win[i] = sorted_win[i - 1];
        i--;
      end
      sorted_win[i] = s;
      n++;
      arrivals[w] = s;
      w++;
      if (w >= k) w = 0;
      fill = n;
      widx = w;
      if (n < k) return;
      if (k % 2 == 1) begin
        lo = sorted_win[k / 2];
        expected_medians.insert(expected_medians.size(), lo + lo);
      end else begin
        lo = sorted_win[k / 2 - 1];
        hi = sorted_win[k / 2];
        expected_medians.insert(expected_medians.size(), lo + hi);
      end
    endfunction

    // Compare one accepted median with the oldest expectation
    function void take_median(logic signed [32:0] got);
      logic signed [32:0] want;
      if (expected_medians.size() == 0) begin
        $error("median_doubled: no expectation waiting, actual %0d", got);
        errors++;
        return;
      end
      want = expected_medians.pop_front();
      if (got !== want) begin
        $error("median_doubled: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  median_scoreboard sb;

  sliding_window_median DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // Sample mix: full range, a crowded small range for ties, and the extremes
  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom();
    if (r < 75) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 85) return ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
    if (r < 93) return S_MIN + 32'($urandom_range(0, 3));
    return S_MAX - 32'($urandom_range(0, 3));
  endfunction

  // Offer one sample request and hold it until accepted
  task automatic send_sample(input logic [31:0] s, input bit burst);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(s);
  endtask

  // Stop offering, wait for every expected median, then let the block settle
  task automatic wait_medians_done(input int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_medians.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready
  task automatic apb_write(input logic [swm_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_window(addr, data);
  endtask

  // Receiver: random ready runs and gaps, one long hold-off on request
  initial begin
    int run;
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Check each accepted median
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.take_median(out_tdata[32:0]);
  end

  // Cycle limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("sliding_window_median: mismatch");
    $finish;
  end

  initial begin
    int         phase;
    int         counted;
    int         n_items;
    int         k;
    int         r;
    logic [6:0] ws;
    logic [31:0] wdata;
    bit         burst;
    localparam logic [swm_pkg::CFG_AW-1:0] WS_ADDR  = {swm_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam logic [swm_pkg::CFG_AW-1:0] BAD_ADDR = {REG_UNUSED, 2'b00};

    sb = new();
    hold_results = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of three: extremes, ties, sign crossing
    foreach (ODD_RUN[i]) send_sample(ODD_RUN[i], 1'b0);
    wait_medians_done(SETTLE_CYCLES);

    // Even window: sums of the two middle extremes
    apb_write(WS_ADDR, 32'd2);
    foreach (EVEN_RUN[i]) send_sample(EVEN_RUN[i], 1'b0);
    wait_medians_done(SETTLE_CYCLES);

    // Partial fill, then a write to an unused register must not restart the fill
    apb_write(WS_ADDR, 32'd4);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    wait_medians_done(SETTLE_CYCLES);
    apb_write(BAD_ADDR, $urandom());
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'h0000_FFFF, 1'b0);
    send_sample(32'h0000_0003, 1'b0);
    wait_medians_done(SETTLE_CYCLES);

    // Zero window drops samples; window of one echoes them doubled
    apb_write(WS_ADDR, 32'd0);
    send_sample($urandom(), 1'b0);
    send_sample($urandom(), 1'b0);
    wait_medians_done(SETTLE_CYCLES);
    apb_write(WS_ADDR, 32'd1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    wait_medians_done(SETTLE_CYCLES);

    // Random phases, each under a new window size
    phase   = 0;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (phase < 5) begin
        ws = 7'(FORCED_WS[phase]);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      ws = 7'($urandom_range(1, 9));
        else if (r < 72) ws = 7'($urandom_range(10, 40));
        else if (r < 77) ws = 7'd0;
        else if (r < 90) ws = 7'($urandom_range(41, 64));
        else             ws = 7'($urandom_range(65, 127));
      end
      wdata = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_FF80) : 32'h0;
      wdata = wdata | 32'(ws);
      apb_write(WS_ADDR, wdata);
      k = (ws > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : int'(ws);
      if (k == 0)       n_items = $urandom_range(5, 20);
      else if (k > 40)  n_items = k + $urandom_range(20, 80);
      else              n_items = $urandom_range(30, 120);
      if (phase == 1) n_items = 150;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
        // stall the receiver long enough to back up the input
        if (phase == 1 && i == 20) hold_results = 1'b1;
        // pause the sender until the pipe is empty
        if (phase == 1 && i == 120) wait_medians_done(0);
        send_sample(rand_sample(), burst);
        if (k != 0) counted++;
      end
      wait_medians_done(SETTLE_CYCLES);
      phase++;
    end

    if (sb.errors == 0 && sb.expected_medians.size() == 0) begin
      $display("sliding_window_median: match");
    end else begin
      $display("sliding_window_median: mismatch");
    end
    $finish;
  end

endmodule

### sliding_window_median.f
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_ctrl.sv
rtl/swm_dp.sv
rtl/sliding_window_median.sv
dv/tb.sv
